FILE: src/ids_pkg.sv
// Shared types and constants for the indentation scanner.
// Used by ids_ctrl, ids_dp, the top level and the port checker.
package ids_pkg;

   localparam int COL_W = 16;
   localparam logic [COL_W-1:0] COL_MAX = '1;
   localparam int TAB_W = 5;
   localparam logic [TAB_W-1:0] TAB_RESET = 5'd4;
   localparam int RUN_W = 5;
   localparam logic [RUN_W-1:0] MAX_RUN = 5'd31;

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;

   typedef enum logic [1:0] {
      TOK_NEWLINE = 2'd0,
      TOK_INDENT  = 2'd1,
      TOK_DEDENT  = 2'd2
   } tok_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;   // accept the presented input transaction
      logic step;   // emit one more DEDENT of a run
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic emit_load;   // the presented item produces a token
      logic more_load;   // that token opens a run of further DEDENTs
      logic more_step;   // another DEDENT follows the current step
   } sts_type;

endpackage

FILE: src/ids_ctrl.sv
// Controller of the indentation scanner: handshake, run sequencing and
// output valid. Depends on ids_pkg.
module ids_ctrl
   import ids_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.load  = 1'b0;
      cmd.step  = 1'b0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = !out_free;
            cmd.load  = req_valid && out_free;
            if (cmd.load && sts.emit_load && sts.more_load) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.step = out_free;
            if (cmd.step && !sts.more_step) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // A new token lands in the output register whenever one is produced.
      if ((cmd.load && sts.emit_load) || cmd.step) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

endmodule

FILE: src/ids_dp.sv
// Datapath of the indentation scanner: column, level stack memory, top of
// stack, run counter and output payload. Depends on ids_pkg.
module ids_dp
   import ids_pkg::*;
#(
   parameter int LEVEL_DEPTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_en,
   input  logic [TAB_W-1:0] csr_tab_width,
   input  logic [7:0]       req_char_code,
   input  logic             req_end_of_input,
   input  logic             req_indent_ok,
   input  logic             req_dedent_ok,
   input  logic             req_newline_ok,
   input  cmd_type          cmd,
   output sts_type          sts,
   output tok_type          token_kind,
   output logic             last_of_run
);

   localparam int CW = $clog2(LEVEL_DEPTH + 1);
   localparam int IW = $clog2(LEVEL_DEPTH);

   logic [COL_W-1:0] mem [LEVEL_DEPTH];
   logic [COL_W-1:0] rd_ff;
   logic             base_ff;

   logic [TAB_W-1:0] tab_ff;
   logic [CW-1:0]    count_ff, count_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             nl_ff, nl_in;
   logic [COL_W-1:0] top_ff, top_in;
   logic [COL_W-1:0] limit_ff, limit_in;
   logic             all_ff, all_in;
   logic [RUN_W-1:0] run_ff, run_in;
   tok_type          token_ff;
   logic             last_ff;

   logic [COL_W-1:0] below;
   logic [COL_W:0]   col_sum;
   logic [COL_W-1:0] col_sat;
   logic             deep_run;
   logic             dec_emit, dec_push, dec_pop, dec_more, dec_run;
   tok_type          dec_kind;
   logic             push, pop;
   logic [IW-1:0]    rd_addr;

   // Column held by the level just under the top one; the base level is 0.
   assign below    = base_ff ? '0 : rd_ff;
   assign deep_run = count_ff > CW'(2);

   always_comb begin
      if (req_char_code == CHAR_TAB) begin
         col_sum = {1'b0, col_ff} + (COL_W + 1)'(tab_ff);
      end else begin
         col_sum = {1'b0, col_ff} + (COL_W + 1)'(1);
      end
      col_sat = col_sum[COL_W] ? COL_MAX : col_sum[COL_W-1:0];
   end

   // Decode of the presented item.
   always_comb begin
      dec_emit = 1'b0;
      dec_push = 1'b0;
      dec_pop  = 1'b0;
      dec_more = 1'b0;
      dec_run  = 1'b0;
      dec_kind = TOK_NEWLINE;
      if (req_end_of_input) begin
         if (req_dedent_ok && count_ff > CW'(1)) begin
            dec_emit = 1'b1;
            dec_pop  = 1'b1;
            dec_kind = TOK_DEDENT;
            dec_more = deep_run;
         end
      end else if (nl_ff && req_char_code != CHAR_LF && req_char_code != CHAR_SPACE &&
                   req_char_code != CHAR_TAB && req_char_code != CHAR_CR) begin
         if (col_ff > top_ff && req_indent_ok) begin
            if (count_ff < CW'(LEVEL_DEPTH)) begin
               dec_emit = 1'b1;
               dec_push = 1'b1;
               dec_kind = TOK_INDENT;
            end
         end else if (col_ff < top_ff && req_dedent_ok) begin
            dec_emit = 1'b1;
            dec_pop  = 1'b1;
            dec_run  = 1'b1;
            dec_kind = TOK_DEDENT;
            dec_more = deep_run && (below > col_ff);
         end else if (req_newline_ok) begin
            dec_emit = 1'b1;
            dec_kind = TOK_NEWLINE;
         end
      end
   end

   assign sts.emit_load = dec_emit;
   assign sts.more_load = dec_more;
   assign sts.more_step = (run_ff < MAX_RUN - RUN_W'(1)) && deep_run &&
                          (all_ff || below > limit_ff);

   assign push = cmd.load && dec_push;
   assign pop  = (cmd.load && dec_pop) || cmd.step;

   always_comb begin
      col_in   = col_ff;
      nl_in    = nl_ff;
      limit_in = limit_ff;
      all_in   = all_ff;
      run_in   = run_ff;
      if (cmd.load) begin
         if (req_end_of_input) begin
            all_in = 1'b1;
            run_in = RUN_W'(1);
         end else begin
            case (req_char_code) inside
               CHAR_LF: begin
                  nl_in  = 1'b1;
                  col_in = '0;
               end
               CHAR_SPACE, CHAR_TAB: col_in = col_sat;
               CHAR_CR: ;
               default: begin
                  nl_in  = 1'b0;
                  col_in = '0;
                  if (dec_run) begin
                     all_in   = 1'b0;
                     limit_in = col_ff;
                     run_in   = RUN_W'(1);
                  end
               end
            endcase
         end
      end else if (cmd.step) begin
         run_in = run_ff + RUN_W'(1);
      end

      if (push) begin
         count_in = count_ff + CW'(1);
         top_in   = col_ff;
      end else if (pop) begin
         count_in = count_ff - CW'(1);
         top_in   = below;
      end else begin
         count_in = count_ff;
         top_in   = top_ff;
      end
   end

   // The read port follows the level under the next top, so a pop per cycle
   // always finds its new neighbor ready.
   assign rd_addr = IW'(count_in - CW'(2));

   always_ff @(posedge clock) begin
      if (push) begin
         mem[count_ff[IW-1:0]] <= col_ff;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tab_ff   <= TAB_RESET;
         count_ff <= CW'(1);
         col_ff   <= '0;
         nl_ff    <= 1'b0;
         top_ff   <= '0;
         base_ff  <= 1'b0;
      end else begin
         if (csr_write_en) begin
            tab_ff <= csr_tab_width;
         end
         count_ff <= count_in;
         col_ff   <= col_in;
         nl_ff    <= nl_in;
         top_ff   <= top_in;
         base_ff  <= count_in == CW'(2);
      end
   end

   always_ff @(posedge clock) begin
      limit_ff <= limit_in;
      all_ff   <= all_in;
      run_ff   <= run_in;
      if (cmd.load && dec_emit) begin
         token_ff <= dec_kind;
         last_ff  <= !dec_more;
      end else if (cmd.step) begin
         token_ff <= TOK_DEDENT;
         last_ff  <= !sts.more_step;
      end
   end

   assign token_kind  = token_ff;
   assign last_of_run = last_ff;

endmodule

FILE: src/indent_dedent_scanner.sv
// Latency: a token is presented the cycle after its character transaction.
// Throughput, unless the output stalls: one character per cycle; a run of
// DEDENTs holds the input, one per cycle from the stack memory read port.
// Reset (synchronous): one open level at column 0, column and newline flag
// cleared, tab width 4; stack entries above the base are not cleared.
// Top level of the indentation scanner; depends on ids_pkg, ids_ctrl, ids_dp.
module indent_dedent_scanner
   import ids_pkg::*;
#(
   parameter int LEVEL_DEPTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_en,
   input  logic [TAB_W-1:0] csr_tab_width,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_char_code,
   input  logic             req_end_of_input,
   input  logic             req_indent_ok,
   input  logic             req_dedent_ok,
   input  logic             req_newline_ok,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_token_kind,
   output logic             rsp_last_of_run
);

   cmd_type cmd;
   sts_type sts;
   tok_type token_kind;

   ids_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ids_dp #(
      .LEVEL_DEPTH (LEVEL_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_tab_width    (csr_tab_width),
      .req_char_code    (req_char_code),
      .req_end_of_input (req_end_of_input),
      .req_indent_ok    (req_indent_ok),
      .req_dedent_ok    (req_dedent_ok),
      .req_newline_ok   (req_newline_ok),
      .cmd              (cmd),
      .sts              (sts),
      .token_kind       (token_kind),
      .last_of_run      (rsp_last_of_run)
   );

   assign rsp_token_kind = token_kind;

endmodule

FILE: src/ids_checker.sv
// Port-level checks for the indentation scanner, bound to the top level.
// Depends on ids_pkg and indent_dedent_scanner.
module ids_checker
   import ids_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_token_kind,
   input logic       rsp_last_of_run
);

   // A stalled result transaction holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_token_kind) &&
      $stable(rsp_last_of_run))
      else $error("stalled result transaction changed");

   // With a single output register, a blocked result blocks the input.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input accepted while the output register is blocked");

   // Only DEDENTs come in runs.
   a_single_token: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind != TOK_DEDENT |-> rsp_last_of_run)
      else $error("non-DEDENT token not marked last");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_token_kind == TOK_NEWLINE || rsp_token_kind == TOK_INDENT ||
      rsp_token_kind == TOK_DEDENT)
      else $error("undefined token kind");

endmodule

bind indent_dedent_scanner ids_checker u_ids_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_token_kind  (rsp_token_kind),
   .rsp_last_of_run (rsp_last_of_run)
);
